// ===== hw/rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps

package mhpq_pkg;

    // Fixed field widths of the stream channels
    localparam int KEY_IN_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Request kinds carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_ROOT,
        ST_DN_LAST,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    // Heap RAM read address source
    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    // Heap RAM write data source
    typedef enum logic [1:0] {
        WR_KEY,
        WR_RDATA,
        WR_CHILD
    } wr_sel_t;

    // Next value of the hole position
    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ROOT,
        POS_PARENT,
        POS_LEFT,
        POS_RIGHT
    } pos_sel_t;

    typedef struct packed {
        logic     start;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        pos_sel_t pos_sel;
        logic     latch_removed;
        logic     latch_key;
        logic     latch_child;
        logic     finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic pos_zero;
        logic left_out;
        logic right_in;
        logic parent_ge;
        logic left_big;
        logic right_big;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  mhpq_pkg::dp_stat_t  stat,
    output mhpq_pkg::ctrl_cmd_t cmd
);

    import mhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_DELETE) begin
                        state_next = stat.count_zero ? ST_FINISH : ST_DN_ROOT;
                    end else begin
                        state_next = stat.count_full ? ST_FINISH : ST_UP_CHK;
                    end
                end
            end
            ST_UP_CHK:  state_next = stat.pos_zero ? ST_FINISH : ST_UP_CMP;
            ST_UP_CMP:  state_next = stat.parent_ge ? ST_FINISH : ST_UP_CHK;
            ST_DN_ROOT: state_next = stat.count_zero ? ST_FINISH : ST_DN_LAST;
            ST_DN_LAST: state_next = ST_DN_RDL;
            ST_DN_RDL:  state_next = stat.left_out ? ST_FINISH : ST_DN_RDR;
            ST_DN_RDR:  state_next = ST_DN_CMP;
            ST_DN_CMP: begin
                state_next = (stat.right_big || stat.left_big) ? ST_DN_RDL : ST_FINISH;
            end
            ST_FINISH:  state_next = stat.out_free ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        s_tready          = 1'b0;
        cmd               = '0;
        cmd.rd_sel        = RD_ROOT;
        cmd.wr_sel        = WR_KEY;
        cmd.pos_sel       = POS_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid && (s_tuser == REQ_DELETE) && !stat.count_zero) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ROOT;
                end
            end
            ST_UP_CHK: begin
                if (stat.pos_zero) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_KEY;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                end
            end
            ST_UP_CMP: begin
                cmd.wr_en = 1'b1;
                if (stat.parent_ge) begin
                    cmd.wr_sel = WR_KEY;
                end else begin
                    cmd.wr_sel  = WR_RDATA;
                    cmd.pos_sel = POS_PARENT;
                end
            end
            ST_DN_ROOT: begin
                cmd.latch_removed = 1'b1;
                if (!stat.count_zero) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                end
            end
            ST_DN_LAST: begin
                cmd.latch_key = 1'b1;
                cmd.pos_sel   = POS_ROOT;
            end
            ST_DN_RDL: begin
                if (stat.left_out) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_KEY;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LEFT;
                end
            end
            ST_DN_RDR: begin
                cmd.latch_child = 1'b1;
                if (stat.right_in) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_RIGHT;
                end
            end
            ST_DN_CMP: begin
                cmd.wr_en = 1'b1;
                priority if (stat.right_big) begin
                    cmd.wr_sel  = WR_RDATA;
                    cmd.pos_sel = POS_RIGHT;
                end else if (stat.left_big) begin
                    cmd.wr_sel  = WR_CHILD;
                    cmd.pos_sel = POS_LEFT;
                end else begin
                    cmd.wr_sel = WR_KEY;
                end
            end
            ST_FINISH: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                cmd.finish = 1'b0;
            end
        endcase
    end

    // Heap RAM: never read and write in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_en && cmd.wr_en))
        else $error("heap RAM read and write issued together");

endmodule

// ===== hw/rtl/mhpq_dp.sv =====
`timescale 1ns / 1ps

module mhpq_dp #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [mhpq_pkg::STATUS_W-1:0]       m_tuser,
    input  mhpq_pkg::ctrl_cmd_t                 cmd,
    output mhpq_pkg::dp_stat_t                  stat
);

    import mhpq_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = AW + 2;
    localparam int CXW = CW + COUNT_OUT_W;
    localparam int PAD = M_TDATA_W - KEY_IN_W - COUNT_OUT_W;

    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           pos_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic [KEY_WIDTH-1:0]    child_reg;
    logic [KEY_IN_W-1:0]     removed_reg;
    logic [STATUS_W-1:0]     status_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic [STATUS_W-1:0]     m_tuser_reg;

    logic [KEY_WIDTH-1:0]    key_ext;
    logic [KEY_WIDTH-1:0]    rdata;
    logic [KEY_IN_W-1:0]     rdata_out;
    logic [KEY_WIDTH-1:0]    best;
    logic [KEY_WIDTH-1:0]    wr_data;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           parent_idx;
    logic [IW-1:0]           left_idx;
    logic [IW-1:0]           right_idx;
    logic [IW-1:0]           count_idx;
    logic [CXW-1:0]          count_wide;
    logic                    req_delete;

    // Key width adaption: sign-extend or truncate at the boundary
    if (KEY_WIDTH > KEY_IN_W) begin : g_key_wide
        assign key_ext   = {{(KEY_WIDTH - KEY_IN_W){s_tdata[KEY_IN_W-1]}}, s_tdata};
        assign rdata_out = rdata[KEY_IN_W-1:0];
    end else if (KEY_WIDTH == KEY_IN_W) begin : g_key_same
        assign key_ext   = s_tdata;
        assign rdata_out = rdata;
    end else begin : g_key_narrow
        assign key_ext   = s_tdata[KEY_WIDTH-1:0];
        assign rdata_out = {{(KEY_IN_W - KEY_WIDTH){rdata[KEY_WIDTH-1]}}, rdata};
    end

    // Tree navigation around the hole
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = (IW'(pos_reg) << 1) + IW'(1);
    assign right_idx  = left_idx + IW'(1);
    assign count_idx  = IW'(count_reg);
    assign req_delete = (s_tuser == REQ_DELETE);

    // Comparisons for sift steps
    always_comb begin
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CW'(CAPACITY));
        stat.pos_zero   = (pos_reg == '0);
        stat.left_out   = (left_idx >= count_idx);
        stat.right_in   = (right_idx < count_idx);
        stat.parent_ge  = ($signed(rdata) >= $signed(key_reg));
        stat.left_big   = ($signed(child_reg) > $signed(key_reg));
        best            = stat.left_big ? child_reg : key_reg;
        stat.right_big  = stat.right_in && ($signed(rdata) > $signed(best));
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // RAM address and data selection
    always_comb begin
        unique case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_LAST:   rd_addr = AW'(count_reg);
            RD_PARENT: rd_addr = parent_idx;
            RD_LEFT:   rd_addr = left_idx[AW-1:0];
            RD_RIGHT:  rd_addr = right_idx[AW-1:0];
            default:   rd_addr = '0;
        endcase
        unique case (cmd.wr_sel)
            WR_KEY:   wr_data = key_reg;
            WR_RDATA: wr_data = rdata;
            WR_CHILD: wr_data = child_reg;
            default:  wr_data = key_reg;
        endcase
    end

    mhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (pos_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata)
    );

    // Entry count: adjust once per accepted request that is not refused as full or empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.start) begin
            if (!req_delete && !stat.count_full) begin
                count_reg <= count_reg + CW'(1);
            end else if (req_delete && !stat.count_zero) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Working registers of the sift
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg     <= key_ext;
            pos_reg     <= AW'(count_reg);
            removed_reg <= '0;
            if (!req_delete && stat.count_full) begin
                status_reg <= STAT_FULL;
            end else if (req_delete && stat.count_zero) begin
                status_reg <= STAT_EMPTY;
            end else begin
                status_reg <= STAT_DONE;
            end
        end else begin
            if (cmd.latch_key) begin
                key_reg <= rdata;
            end
            if (cmd.latch_removed) begin
                removed_reg <= rdata_out;
            end
            unique case (cmd.pos_sel)
                POS_HOLD:   pos_reg <= pos_reg;
                POS_ROOT:   pos_reg <= '0;
                POS_PARENT: pos_reg <= parent_idx;
                POS_LEFT:   pos_reg <= left_idx[AW-1:0];
                POS_RIGHT:  pos_reg <= right_idx[AW-1:0];
                default:    pos_reg <= pos_reg;
            endcase
        end
        if (cmd.latch_child) begin
            child_reg <= rdata;
        end
    end

    // Output register: hold a result until the sink takes it
    assign count_wide = CXW'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {{PAD{1'b0}}, count_wide[COUNT_OUT_W-1:0], removed_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (IW'(pos_reg) < count_idx))
        else $error("heap write outside the held entries");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(cmd.start) |-> $stable(count_reg))
        else $error("entry count changed outside request start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result appeared without a finished request");

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// An insert when full or a delete when empty goes straight to its result with no heap access.
// Insert: the key climbs level by level until its parent is not smaller or it reaches the root.
// Delete: the root is removed; if entries remain, the last entry sifts down from the root.
// One request at a time: the next input transfer comes in the cycle after the result loads,
// later while m_tready stalls.
// Reset clears the entry count, control and output valid; the heap RAM is not cleared.

module max_heap_priority_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] key_in
    input  logic                               s_tuser,   // [0] req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] removed_key, [38:32] count_after
    output logic [mhpq_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);

    import mhpq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
